@@ sv/rrt_ne_pkg.sv @@
// Shared types and constants for the RRT nearest-node and steer engine.
package rrt_ne_pkg;

  localparam int MAX_NODES = 1024;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = IDX_W + 1;
  localparam int COORD_W   = 16;
  localparam int PAR_W     = 11;
  localparam int GAIN_W    = 32;
  localparam int STEP_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFGI_W    = 2;

  // Steering datapath widths
  localparam int DIFF_W    = COORD_W + 1;
  localparam int SQ_W      = 2 * DIFF_W - 1;
  localparam int D2_W      = SQ_W + 1;
  localparam int RAD_W     = D2_W + 16;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int SREM_W    = ROOT_W + 2;
  localparam int PROD_W    = STEP_W + DIFF_W;
  localparam int DVD_W     = PROD_W + 9;
  localparam int DREM_W    = ROOT_W + 1;
  localparam int SUM_W     = DVD_W + 2;

  localparam logic [1:0] CMD_RESTART = 2'd0;
  localparam logic [1:0] CMD_EXTEND  = 2'd1;
  localparam logic [1:0] CMD_ADD     = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;
  localparam logic [1:0] STAT_EMPTY = 2'd3;

  localparam logic [CFGI_W-1:0] CFG_START_X = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_START_Y = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_STEP    = 2'd2;

  localparam logic [PAR_W-1:0] NO_PARENT = '1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [COORD_W-1:0] sample_x;
    logic [COORD_W-1:0] sample_y;
    logic [GAIN_W-1:0]  gain_in;
    logic [9:0]         target_node;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [9:0]         node_index;
    logic [COORD_W-1:0] node_x;
    logic [COORD_W-1:0] node_y;
    logic [PAR_W-1:0]   parent_index;
    logic [GAIN_W-1:0]  gain_total;
  } out_beat_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PAR_W-1:0]   parent;
    logic [GAIN_W-1:0]  gain;
  } node_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_SCAN,
    ST_NEAR_RD,
    ST_NEAR_DATA,
    ST_SQRT,
    ST_MUL,
    ST_DIV_INIT,
    ST_DIV,
    ST_STEP,
    ST_FIN,
    ST_EMIT
  } state_t;

endpackage

@@ sv/rrt_nearest_extend_engine.sv @@
// Node table with nearest-node scan, square root and divide steering.
//
//  channel | ports                          | direction
//  --------+--------------------------------+----------
//  in      | in_valid, in_stall, in_data    | into block
//  out     | out_valid, out_stall, out_data | out of block
//  cfg     | cfg_wr_en, cfg_index, cfg_data | into block
//
// Restart, bad command, empty tree and out-of-range add go straight to emit; add gain
// reads the node and writes it back first. Extend scans the table through the one read
// port, takes a bit-serial square root (one result bit each step), then a bit-serial
// divide per axis. A sample on its nearest node skips the steering.
// One item is in work at a time; the next beat is taken once the result sits in the
// output register. Reset empties the tree; table contents are kept only by node_total.
// Output stall holds the result register and the block waits for it to free.
module rrt_nearest_extend_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rrt_ne_pkg::in_beat_t                in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rrt_ne_pkg::out_beat_t               out_data,
  input  logic                                cfg_wr_en,
  input  logic [rrt_ne_pkg::CFGI_W-1:0]       cfg_index,
  input  logic [rrt_ne_pkg::CFG_W-1:0]        cfg_data
);

  rrt_ne_pkg::state_t state_r, state_nxt;

  logic [rrt_ne_pkg::COORD_W-1:0] start_x_r, start_y_r;
  logic [rrt_ne_pkg::STEP_W-1:0]  step_r;

  rrt_ne_pkg::node_t mem [rrt_ne_pkg::MAX_NODES];
  rrt_ne_pkg::node_t rd_q;
  rrt_ne_pkg::node_t mem_wd;
  logic                          mem_we;
  logic [rrt_ne_pkg::IDX_W-1:0]  mem_wa, mem_ra;

  rrt_ne_pkg::in_beat_t  item_r, item_nxt;
  rrt_ne_pkg::out_beat_t res_r, res_nxt;
  rrt_ne_pkg::out_beat_t out_r;
  logic                  out_valid_r;
  logic                  accept, load_out;

  logic [rrt_ne_pkg::CNT_W-1:0] node_total_r, node_total_nxt;
  logic [rrt_ne_pkg::CNT_W-1:0] scan_i_r, scan_i_nxt;
  logic                         issue;

  // scan pipeline
  logic                                v1_r, v2_r, v3_r;
  logic [rrt_ne_pkg::IDX_W-1:0]        idx1_r, idx2_r, idx3_r;
  logic signed [rrt_ne_pkg::DIFF_W-1:0] dx2_r, dy2_r, dx3_r, dy3_r;
  logic signed [rrt_ne_pkg::DIFF_W-1:0] dx_c, dy_c;
  logic [rrt_ne_pkg::SQ_W-1:0]         sqx3_r, sqy3_r;
  logic signed [2*rrt_ne_pkg::DIFF_W-1:0] sqx_full, sqy_full;
  logic [rrt_ne_pkg::D2_W-1:0]         d_c;

  logic [rrt_ne_pkg::D2_W-1:0]          best_d_r, best_d_nxt;
  logic [rrt_ne_pkg::IDX_W-1:0]         best_i_r, best_i_nxt;
  logic signed [rrt_ne_pkg::DIFF_W-1:0] best_dx_r, best_dx_nxt, best_dy_r, best_dy_nxt;

  logic [rrt_ne_pkg::COORD_W-1:0] near_x_r, near_x_nxt, near_y_r, near_y_nxt;
  logic [rrt_ne_pkg::GAIN_W-1:0]  near_g_r, near_g_nxt;
  logic [rrt_ne_pkg::COORD_W-1:0] new_x_r, new_x_nxt, new_y_r, new_y_nxt;

  // square root
  logic [rrt_ne_pkg::RAD_W-1:0]  sq_n_r, sq_n_nxt;
  logic [rrt_ne_pkg::SREM_W-1:0] sq_rem_r, sq_rem_nxt, sq_rem_t, sq_trial;
  logic [rrt_ne_pkg::ROOT_W-1:0] root_r, root_nxt;

  // divide
  logic                          axis_r, axis_nxt;
  logic [rrt_ne_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [rrt_ne_pkg::DIFF_W-1:0] mag_c;
  logic signed [rrt_ne_pkg::DIFF_W-1:0] dsel_c;
  logic [rrt_ne_pkg::DVD_W-1:0]  dv_n_r, dv_n_nxt, quo_r, quo_nxt;
  logic [rrt_ne_pkg::DREM_W-1:0] dv_rem_r, dv_rem_nxt, dv_rem_t;
  logic [5:0]                    cnt_r, cnt_nxt;
  logic signed [rrt_ne_pkg::SUM_W-1:0] sum_c, off_c;
  logic [rrt_ne_pkg::COORD_W-1:0] sat_c;
  logic [rrt_ne_pkg::GAIN_W-1:0]  ng_c;

  assign accept    = in_valid && !in_stall;
  assign load_out  = (state_r == rrt_ne_pkg::ST_EMIT) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign issue     = (state_r == rrt_ne_pkg::ST_SCAN) && (scan_i_r < node_total_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0;
      start_y_r <= '0;
      step_r    <= rrt_ne_pkg::STEP_W'(512);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rrt_ne_pkg::CFG_START_X: start_x_r <= cfg_data;
        rrt_ne_pkg::CFG_START_Y: start_y_r <= cfg_data;
        rrt_ne_pkg::CFG_STEP:    step_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // node table
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[mem_ra];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rrt_ne_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_data.cmd == rrt_ne_pkg::CMD_RESTART) state_nxt = rrt_ne_pkg::ST_EMIT;
          else if (in_data.cmd != rrt_ne_pkg::CMD_EXTEND && in_data.cmd != rrt_ne_pkg::CMD_ADD)
            state_nxt = rrt_ne_pkg::ST_EMIT;
          else if (node_total_r == '0) state_nxt = rrt_ne_pkg::ST_EMIT;
          else if (in_data.cmd == rrt_ne_pkg::CMD_ADD)
            state_nxt = ({1'b0, in_data.target_node} >= node_total_r) ?
                        rrt_ne_pkg::ST_EMIT : rrt_ne_pkg::ST_ADD_RD;
          else state_nxt = rrt_ne_pkg::ST_SCAN;
        end
      end
      rrt_ne_pkg::ST_ADD_RD:  state_nxt = rrt_ne_pkg::ST_ADD_WR;
      rrt_ne_pkg::ST_ADD_WR:  state_nxt = rrt_ne_pkg::ST_EMIT;
      rrt_ne_pkg::ST_SCAN:
        if (!issue && !v1_r && !v2_r && !v3_r) state_nxt = rrt_ne_pkg::ST_NEAR_RD;
      rrt_ne_pkg::ST_NEAR_RD: state_nxt = rrt_ne_pkg::ST_NEAR_DATA;
      rrt_ne_pkg::ST_NEAR_DATA:
        state_nxt = (best_d_r == '0) ? rrt_ne_pkg::ST_FIN : rrt_ne_pkg::ST_SQRT;
      rrt_ne_pkg::ST_SQRT:    if (cnt_r == 6'd1) state_nxt = rrt_ne_pkg::ST_MUL;
      rrt_ne_pkg::ST_MUL:     state_nxt = rrt_ne_pkg::ST_DIV_INIT;
      rrt_ne_pkg::ST_DIV_INIT: state_nxt = rrt_ne_pkg::ST_DIV;
      rrt_ne_pkg::ST_DIV:     if (cnt_r == 6'd1) state_nxt = rrt_ne_pkg::ST_STEP;
      rrt_ne_pkg::ST_STEP:    state_nxt = axis_r ? rrt_ne_pkg::ST_FIN : rrt_ne_pkg::ST_MUL;
      rrt_ne_pkg::ST_FIN:     state_nxt = rrt_ne_pkg::ST_EMIT;
      rrt_ne_pkg::ST_EMIT:    if (load_out) state_nxt = rrt_ne_pkg::ST_IDLE;
      default:                state_nxt = rrt_ne_pkg::ST_IDLE;
    endcase
  end

  // control outputs: handshake and table port
  always_comb begin
    in_stall = (state_r != rrt_ne_pkg::ST_IDLE);
    mem_we   = 1'b0;
    mem_wa   = '0;
    mem_wd   = '0;
    mem_ra   = '0;
    ng_c     = item_r.gain_in + near_g_r;
    case (state_r)
      rrt_ne_pkg::ST_IDLE: begin
        if (accept && in_data.cmd == rrt_ne_pkg::CMD_RESTART) begin
          mem_we = 1'b1;
          mem_wd = '{x: start_x_r, y: start_y_r, parent: rrt_ne_pkg::NO_PARENT, gain: '0};
        end
      end
      rrt_ne_pkg::ST_ADD_RD:  mem_ra = item_r.target_node[rrt_ne_pkg::IDX_W-1:0];
      rrt_ne_pkg::ST_ADD_WR: begin
        mem_we = 1'b1;
        mem_wa = item_r.target_node[rrt_ne_pkg::IDX_W-1:0];
        mem_wd = rd_q;
        mem_wd.gain = rd_q.gain + item_r.gain_in;
      end
      rrt_ne_pkg::ST_SCAN:    mem_ra = scan_i_r[rrt_ne_pkg::IDX_W-1:0];
      rrt_ne_pkg::ST_NEAR_RD: mem_ra = best_i_r;
      rrt_ne_pkg::ST_FIN: begin
        if (node_total_r < rrt_ne_pkg::CNT_W'(rrt_ne_pkg::MAX_NODES)) begin
          mem_we = 1'b1;
          mem_wa = node_total_r[rrt_ne_pkg::IDX_W-1:0];
          mem_wd = '{x: new_x_r, y: new_y_r,
                     parent: rrt_ne_pkg::PAR_W'(best_i_r), gain: ng_c};
        end
      end
      default: ;
    endcase
  end

  // scan, square root, divide and saturation datapath pieces
  always_comb begin
    dx_c     = $signed({item_r.sample_x[rrt_ne_pkg::COORD_W-1], item_r.sample_x})
             - $signed({rd_q.x[rrt_ne_pkg::COORD_W-1], rd_q.x});
    dy_c     = $signed({item_r.sample_y[rrt_ne_pkg::COORD_W-1], item_r.sample_y})
             - $signed({rd_q.y[rrt_ne_pkg::COORD_W-1], rd_q.y});
    sqx_full = dx2_r * dx2_r;
    sqy_full = dy2_r * dy2_r;
    d_c      = {1'b0, sqx3_r} + {1'b0, sqy3_r};
    sq_rem_t = {sq_rem_r[rrt_ne_pkg::SREM_W-3:0], sq_n_r[rrt_ne_pkg::RAD_W-1 -: 2]};
    sq_trial = {root_r, 2'b01};
    dsel_c   = axis_r ? best_dy_r : best_dx_r;
    mag_c    = dsel_c[rrt_ne_pkg::DIFF_W-1] ? rrt_ne_pkg::DIFF_W'(-dsel_c) : dsel_c;
    dv_rem_t = {dv_rem_r[rrt_ne_pkg::DREM_W-2:0], dv_n_r[rrt_ne_pkg::DVD_W-1]};
    off_c    = dsel_c[rrt_ne_pkg::DIFF_W-1] ? -$signed({2'b00, quo_r})
                                            : $signed({2'b00, quo_r});
    sum_c    = off_c + rrt_ne_pkg::SUM_W'($signed(axis_r ? near_y_r : near_x_r));
    if (sum_c > rrt_ne_pkg::SUM_W'(32767))       sat_c = 16'h7FFF;
    else if (sum_c < -rrt_ne_pkg::SUM_W'(32768)) sat_c = 16'h8000;
    else                                         sat_c = sum_c[rrt_ne_pkg::COORD_W-1:0];
  end

  // datapath next values
  always_comb begin
    item_nxt       = item_r;
    res_nxt        = res_r;
    node_total_nxt = node_total_r;
    scan_i_nxt     = scan_i_r;
    best_d_nxt     = best_d_r;
    best_i_nxt     = best_i_r;
    best_dx_nxt    = best_dx_r;
    best_dy_nxt    = best_dy_r;
    near_x_nxt     = near_x_r;
    near_y_nxt     = near_y_r;
    near_g_nxt     = near_g_r;
    new_x_nxt      = new_x_r;
    new_y_nxt      = new_y_r;
    sq_n_nxt       = sq_n_r;
    sq_rem_nxt     = sq_rem_r;
    root_nxt       = root_r;
    axis_nxt       = axis_r;
    prod_nxt       = prod_r;
    dv_n_nxt       = dv_n_r;
    dv_rem_nxt     = dv_rem_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    case (state_r)
      rrt_ne_pkg::ST_IDLE: begin
        if (accept) begin
          item_nxt   = in_data;
          res_nxt    = '0;
          scan_i_nxt = '0;
          if (in_data.cmd == rrt_ne_pkg::CMD_RESTART) begin
            node_total_nxt       = rrt_ne_pkg::CNT_W'(1);
            res_nxt.node_x       = start_x_r;
            res_nxt.node_y       = start_y_r;
            res_nxt.parent_index = rrt_ne_pkg::NO_PARENT;
          end else if (in_data.cmd != rrt_ne_pkg::CMD_EXTEND &&
                       in_data.cmd != rrt_ne_pkg::CMD_ADD) begin
            res_nxt.status = rrt_ne_pkg::STAT_RANGE;
          end else if (node_total_r == '0) begin
            res_nxt.status = rrt_ne_pkg::STAT_EMPTY;
          end else if (in_data.cmd == rrt_ne_pkg::CMD_ADD &&
                       {1'b0, in_data.target_node} >= node_total_r) begin
            res_nxt.status = rrt_ne_pkg::STAT_RANGE;
          end
        end
      end
      rrt_ne_pkg::ST_ADD_WR: begin
        res_nxt.node_index   = item_r.target_node;
        res_nxt.node_x       = rd_q.x;
        res_nxt.node_y       = rd_q.y;
        res_nxt.parent_index = rd_q.parent;
        res_nxt.gain_total   = rd_q.gain + item_r.gain_in;
      end
      rrt_ne_pkg::ST_SCAN: begin
        if (issue) scan_i_nxt = scan_i_r + 1'b1;
        // ties keep the earlier node: strict compare only
        if (v3_r && (idx3_r == '0 || d_c < best_d_r)) begin
          best_d_nxt  = d_c;
          best_i_nxt  = idx3_r;
          best_dx_nxt = dx3_r;
          best_dy_nxt = dy3_r;
        end
      end
      rrt_ne_pkg::ST_NEAR_DATA: begin
        near_x_nxt = rd_q.x;
        near_y_nxt = rd_q.y;
        near_g_nxt = rd_q.gain;
        new_x_nxt  = rd_q.x;
        new_y_nxt  = rd_q.y;
        sq_n_nxt   = {best_d_r, 16'h0000};
        sq_rem_nxt = '0;
        root_nxt   = '0;
        axis_nxt   = 1'b0;
        cnt_nxt    = 6'(rrt_ne_pkg::ROOT_W);
      end
      rrt_ne_pkg::ST_SQRT: begin
        sq_n_nxt = sq_n_r << 2;
        cnt_nxt  = cnt_r - 1'b1;
        if (sq_rem_t >= sq_trial) begin
          sq_rem_nxt = sq_rem_t - sq_trial;
          root_nxt   = {root_r[rrt_ne_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          sq_rem_nxt = sq_rem_t;
          root_nxt   = {root_r[rrt_ne_pkg::ROOT_W-2:0], 1'b0};
        end
      end
      rrt_ne_pkg::ST_MUL: prod_nxt = step_r * mag_c;
      rrt_ne_pkg::ST_DIV_INIT: begin
        // add half the divisor for round half away from zero
        dv_n_nxt   = {1'b0, prod_r, 8'h00} + rrt_ne_pkg::DVD_W'(root_r >> 1);
        dv_rem_nxt = '0;
        quo_nxt    = '0;
        cnt_nxt    = 6'(rrt_ne_pkg::DVD_W);
      end
      rrt_ne_pkg::ST_DIV: begin
        dv_n_nxt = dv_n_r << 1;
        cnt_nxt  = cnt_r - 1'b1;
        if (dv_rem_t >= {1'b0, root_r}) begin
          dv_rem_nxt = dv_rem_t - {1'b0, root_r};
          quo_nxt    = {quo_r[rrt_ne_pkg::DVD_W-2:0], 1'b1};
        end else begin
          dv_rem_nxt = dv_rem_t;
          quo_nxt    = {quo_r[rrt_ne_pkg::DVD_W-2:0], 1'b0};
        end
      end
      rrt_ne_pkg::ST_STEP: begin
        if (axis_r) new_y_nxt = sat_c;
        else        new_x_nxt = sat_c;
        axis_nxt = 1'b1;
      end
      rrt_ne_pkg::ST_FIN: begin
        res_nxt.node_x       = new_x_r;
        res_nxt.node_y       = new_y_r;
        res_nxt.parent_index = rrt_ne_pkg::PAR_W'(best_i_r);
        res_nxt.gain_total   = ng_c;
        if (node_total_r < rrt_ne_pkg::CNT_W'(rrt_ne_pkg::MAX_NODES)) begin
          res_nxt.status     = rrt_ne_pkg::STAT_OK;
          res_nxt.node_index = 10'(node_total_r);
          node_total_nxt     = node_total_r + 1'b1;
        end else begin
          res_nxt.status     = rrt_ne_pkg::STAT_FULL;
          res_nxt.node_index = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rrt_ne_pkg::ST_IDLE;
      node_total_r <= '0;
      out_valid_r  <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      node_total_r <= node_total_nxt;
      if (load_out)        out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    res_r     <= res_nxt;
    scan_i_r  <= scan_i_nxt;
    best_d_r  <= best_d_nxt;
    best_i_r  <= best_i_nxt;
    best_dx_r <= best_dx_nxt;
    best_dy_r <= best_dy_nxt;
    near_x_r  <= near_x_nxt;
    near_y_r  <= near_y_nxt;
    near_g_r  <= near_g_nxt;
    new_x_r   <= new_x_nxt;
    new_y_r   <= new_y_nxt;
    sq_n_r    <= sq_n_nxt;
    sq_rem_r  <= sq_rem_nxt;
    root_r    <= root_nxt;
    axis_r    <= axis_nxt;
    prod_r    <= prod_nxt;
    dv_n_r    <= dv_n_nxt;
    dv_rem_r  <= dv_rem_nxt;
    quo_r     <= quo_nxt;
    cnt_r     <= cnt_nxt;
    idx1_r    <= scan_i_r[rrt_ne_pkg::IDX_W-1:0];
    idx2_r    <= idx1_r;
    idx3_r    <= idx2_r;
    dx2_r     <= dx_c;
    dy2_r     <= dy_c;
    dx3_r     <= dx2_r;
    dy3_r     <= dy2_r;
    sqx3_r    <= sqx_full[rrt_ne_pkg::SQ_W-1:0];
    sqy3_r    <= sqy_full[rrt_ne_pkg::SQ_W-1:0];
    if (load_out) out_r <= res_r;
  end

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    node_total_r <= rrt_ne_pkg::CNT_W'(rrt_ne_pkg::MAX_NODES))
    else $error("node count beyond table depth");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rrt_ne_pkg::ST_SCAN |-> !mem_we)
    else $error("table written during scan");

  a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r || v2_r || v3_r) |-> state_r == rrt_ne_pkg::ST_SCAN)
    else $error("scan pipeline busy outside scan");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r && state_r == rrt_ne_pkg::ST_IDLE)
    else $error("result not presented after load");

endmodule

@@ test/rrt_nearest_extend_engine_tb.sv @@
// Self-checking testbench for the RRT nearest-node and steer engine.
module rrt_nearest_extend_engine_tb;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         LIMIT      = 20_000_000;
  localparam int         HOLD_LEN   = 400;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  rrt_ne_pkg::in_beat_t  in_data;
  logic                  out_valid;
  logic                  out_stall;
  rrt_ne_pkg::out_beat_t out_data;
  logic                              cfg_wr_en;
  logic [rrt_ne_pkg::CFGI_W-1:0]     cfg_index;
  logic [rrt_ne_pkg::CFG_W-1:0]      cfg_data;

  rrt_nearest_extend_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Tree model
  logic signed [rrt_ne_pkg::COORD_W-1:0] tree_x [rrt_ne_pkg::MAX_NODES];
  logic signed [rrt_ne_pkg::COORD_W-1:0] tree_y [rrt_ne_pkg::MAX_NODES];
  logic        [rrt_ne_pkg::PAR_W-1:0]   tree_par [rrt_ne_pkg::MAX_NODES];
  logic        [rrt_ne_pkg::GAIN_W-1:0]  tree_gain [rrt_ne_pkg::MAX_NODES];
  int                                    tree_cnt;
  logic signed [rrt_ne_pkg::COORD_W-1:0] root_x, root_y;
  logic        [rrt_ne_pkg::STEP_W-1:0]  step_len;

  rrt_ne_pkg::in_beat_t  pending_beats [$];
  rrt_ne_pkg::out_beat_t expected_nodes [$];
  int        gen_cnt;
  int        errors;
  int        cycles;
  int        send_idle_pct, recv_idle_pct;
  int        hold_go, hold_seen, hold_left;
  logic      taken;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] rnd16();
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] rnd32();
    return 32'($urandom);
  endfunction

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   -= res + bitv;
        res  = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint steer_off(longint d, longint unsigned len);
    longint unsigned mag, q;
    mag = (d < 0) ? -d : d;
    q   = (longint'(step_len) * mag * 256 + len / 2) / len;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [rrt_ne_pkg::COORD_W-1:0] clamp_coord(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[rrt_ne_pkg::COORD_W-1:0];
  endfunction

  // Apply one beat to the tree model and return its result.
  function automatic rrt_ne_pkg::out_beat_t predict_node(rrt_ne_pkg::in_beat_t b);
    rrt_ne_pkg::out_beat_t r;
    int        best;
    longint    dx, dy, bd, d;
    longint    nx, ny;
    longint unsigned len;
    logic [rrt_ne_pkg::GAIN_W-1:0] ng;
    r = '0;
    if (b.cmd == rrt_ne_pkg::CMD_RESTART) begin
      tree_x[0] = root_x; tree_y[0] = root_y;
      tree_par[0] = rrt_ne_pkg::NO_PARENT; tree_gain[0] = '0;
      tree_cnt = 1;
      r.node_x = root_x; r.node_y = root_y; r.parent_index = rrt_ne_pkg::NO_PARENT;
      return r;
    end
    if (b.cmd == CMD_UNUSED) begin
      r.status = rrt_ne_pkg::STAT_RANGE;
      return r;
    end
    if (tree_cnt == 0) begin
      r.status = rrt_ne_pkg::STAT_EMPTY;
      return r;
    end
    if (b.cmd == rrt_ne_pkg::CMD_ADD) begin
      if (b.target_node >= tree_cnt) begin
        r.status = rrt_ne_pkg::STAT_RANGE;
        return r;
      end
      tree_gain[b.target_node] += b.gain_in;
      r.node_index   = b.target_node;
      r.node_x       = tree_x[b.target_node];
      r.node_y       = tree_y[b.target_node];
      r.parent_index = tree_par[b.target_node];
      r.gain_total   = tree_gain[b.target_node];
      return r;
    end
    best = 0;
    bd   = 0;
    for (int i = 0; i < tree_cnt; i++) begin
      dx = longint'($signed(b.sample_x)) - longint'(tree_x[i]);
      dy = longint'($signed(b.sample_y)) - longint'(tree_y[i]);
      d  = dx * dx + dy * dy;
      if (i == 0 || d < bd) begin
        bd   = d;
        best = i;
      end
    end
    dx = longint'($signed(b.sample_x)) - longint'(tree_x[best]);
    dy = longint'($signed(b.sample_y)) - longint'(tree_y[best]);
    nx = tree_x[best];
    ny = tree_y[best];
    if (bd != 0) begin
      len = root64(longint'(bd) << 16);
      nx  = nx + steer_off(dx, len);
      ny  = ny + steer_off(dy, len);
    end
    ng = b.gain_in + tree_gain[best];
    r.node_x       = clamp_coord(nx);
    r.node_y       = clamp_coord(ny);
    r.parent_index = rrt_ne_pkg::PAR_W'(best);
    r.gain_total   = ng;
    if (tree_cnt >= rrt_ne_pkg::MAX_NODES) begin
      r.status = rrt_ne_pkg::STAT_FULL;
      return r;
    end
    tree_x[tree_cnt]    = r.node_x;
    tree_y[tree_cnt]    = r.node_y;
    tree_par[tree_cnt]  = r.parent_index;
    tree_gain[tree_cnt] = ng;
    r.node_index = rrt_ne_pkg::IDX_W'(tree_cnt);
    tree_cnt++;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("  node result %s: got 0x%0h, want 0x%0h", what, got, want);
    errors++;
  endtask

  // Drive: offer a new beat once the previous one is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || taken) begin
      if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= pending_beats.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    taken <= 1'b0;
  end

  // Receiver stall, with a long hold-off on request.
  always @(negedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen = hold_go;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: predict on input beats, check output beats.
  always @(posedge clk) begin
    rrt_ne_pkg::out_beat_t w, p;
    cycles++;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (rst_n && in_valid && !in_stall) begin
      p = predict_node(in_data);
      expected_nodes.insert(expected_nodes.size(), p);
      taken <= 1'b1;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_nodes.size() == 0) begin
        report_mismatch("with nothing expected", out_data.status, 0);
      end else begin
        w = expected_nodes.pop_front();
        if (out_data.status != w.status) report_mismatch("status", out_data.status, w.status);
        if (out_data.node_index != w.node_index)
          report_mismatch("node_index", out_data.node_index, w.node_index);
        if (out_data.node_x != w.node_x) report_mismatch("node_x", out_data.node_x, w.node_x);
        if (out_data.node_y != w.node_y) report_mismatch("node_y", out_data.node_y, w.node_y);
        if (out_data.parent_index != w.parent_index)
          report_mismatch("parent_index", out_data.parent_index, w.parent_index);
        if (out_data.gain_total != w.gain_total)
          report_mismatch("gain_total", out_data.gain_total, w.gain_total);
      end
    end
  end

  task automatic push_beat(logic [1:0] c, logic [15:0] sx, logic [15:0] sy,
                           logic [31:0] g, logic [9:0] t);
    rrt_ne_pkg::in_beat_t b;
    b.cmd = c; b.sample_x = sx; b.sample_y = sy; b.gain_in = g; b.target_node = t;
    pending_beats.insert(pending_beats.size(), b);
    if (c == rrt_ne_pkg::CMD_RESTART) gen_cnt = 1;
    else if (c == rrt_ne_pkg::CMD_EXTEND && gen_cnt > 0 && gen_cnt < rrt_ne_pkg::MAX_NODES)
      gen_cnt++;
  endtask

  task automatic push_random;
    int          roll;
    logic [9:0]  t;
    roll = $urandom_range(99);
    if (gen_cnt > 0 && $urandom_range(3) != 0) t = 10'($urandom_range(gen_cnt - 1));
    else t = 10'($urandom);
    if (roll < 8 || gen_cnt == 0)
      push_beat(rrt_ne_pkg::CMD_RESTART, rnd16(), rnd16(), rnd32(), t);
    else if (roll < 63) push_beat(rrt_ne_pkg::CMD_EXTEND, rnd16(), rnd16(), rnd32(), t);
    else if (roll < 95) push_beat(rrt_ne_pkg::CMD_ADD, rnd16(), rnd16(), rnd32(), t);
    else push_beat(CMD_UNUSED, rnd16(), rnd16(), rnd32(), t);
  endtask

  task automatic drain;
    do begin
      @(posedge clk);
      #1;
    end while (pending_beats.size() != 0 || in_valid || expected_nodes.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [rrt_ne_pkg::CFGI_W-1:0] idx,
                           logic [rrt_ne_pkg::CFG_W-1:0] v);
    @(negedge clk);
    cfg_wr_en = 1'b1; cfg_index = idx; cfg_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx == rrt_ne_pkg::CFG_START_X) root_x = v;
    else if (idx == rrt_ne_pkg::CFG_START_Y) root_y = v;
    else step_len = v;
  endtask

  task automatic set_all(logic [15:0] sx, logic [15:0] sy, logic [15:0] st);
    write_reg(rrt_ne_pkg::CFG_START_X, sx);
    write_reg(rrt_ne_pkg::CFG_START_Y, sy);
    write_reg(rrt_ne_pkg::CFG_STEP, st);
  endtask

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0; out_stall = 1'b0; taken = 1'b0;
    cfg_wr_en = 1'b0; cfg_index = '0; cfg_data = '0;
    root_x = '0; root_y = '0; step_len = 16'd512; tree_cnt = 0; gen_cnt = 0;
    errors = 0; cycles = 0; hold_go = 0; hold_seen = 0; hold_left = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Directed: empty tree, unused command, restart, ties, sample on node, extremes.
    push_beat(rrt_ne_pkg::CMD_ADD, '0, '0, 32'd5, '0);
    push_beat(rrt_ne_pkg::CMD_EXTEND, 16'd100, 16'd100, 32'd1, '0);
    push_beat(CMD_UNUSED, '1, '1, '1, '1);
    push_beat(rrt_ne_pkg::CMD_RESTART, '0, '0, '0, '0);
    push_beat(rrt_ne_pkg::CMD_EXTEND, 16'd1024, 16'd0, 32'h7fffffff, '0);
    push_beat(rrt_ne_pkg::CMD_EXTEND, 16'd256, 16'd0, 32'h1, '0);
    push_beat(rrt_ne_pkg::CMD_EXTEND, 16'd512, 16'd0, 32'h80000000, '0);
    push_beat(rrt_ne_pkg::CMD_EXTEND, 16'h7fff, 16'h8000, 32'hffffffff, '1);
    push_beat(rrt_ne_pkg::CMD_EXTEND, 16'h8000, 16'h7fff, 32'h0, '0);
    push_beat(rrt_ne_pkg::CMD_ADD, '0, '0, 32'h7fffffff, 10'd0);
    push_beat(rrt_ne_pkg::CMD_ADD, '0, '0, 32'h00000001, 10'd1);
    push_beat(rrt_ne_pkg::CMD_ADD, '0, '0, 32'h1, 10'd1023);
    push_beat(rrt_ne_pkg::CMD_ADD, '0, '0, 32'h1, 10'd6);
    push_beat(CMD_UNUSED, '0, '0, '0, '0);
    drain();

    set_all(16'h8000, 16'h7fff, 16'hffff);
    push_beat(rrt_ne_pkg::CMD_RESTART, '0, '0, '0, '0);
    push_beat(rrt_ne_pkg::CMD_EXTEND, 16'h7fff, 16'h8000, 32'h1234, '0);
    push_beat(rrt_ne_pkg::CMD_EXTEND, 16'h0001, 16'h0001, 32'h1, '0);
    push_beat(rrt_ne_pkg::CMD_EXTEND, 16'h8000, 16'h7fff, 32'h1, '0);
    drain();
    set_all(16'h7fff, 16'h8000, 16'h0000);
    push_beat(rrt_ne_pkg::CMD_RESTART, '0, '0, '0, '0);
    push_beat(rrt_ne_pkg::CMD_EXTEND, 16'h0, 16'h0, 32'h5, '0);
    push_beat(rrt_ne_pkg::CMD_EXTEND, 16'h8000, 16'h7fff, 32'h5, '0);
    drain();

    // Random phases under different idling, with a restart so the tree stays small.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 28; recv_idle_pct = 68; set_all('0, '0, 16'd512);
        end
        1: begin
          send_idle_pct = 68; recv_idle_pct = 28; set_all(rnd16(), rnd16(), rnd16());
        end
        default: begin
          send_idle_pct = 0; recv_idle_pct = 0; set_all(rnd16(), rnd16(), 16'd1);
        end
      endcase
      push_beat(rrt_ne_pkg::CMD_RESTART, '0, '0, '0, '0);
      for (int i = 0; i < 85; i++) push_random();
      if (ph == 2) begin
        // Block the receiver while quick restarts pile up at the input.
        @(posedge clk);
        hold_go++;
        for (int i = 0; i < 8; i++) push_beat(rrt_ne_pkg::CMD_RESTART, '0, '0, '0, '0);
      end
      // Pause the sender until everything has come back.
      drain();
      for (int i = 0; i < 85; i++) push_random();
      drain();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/rrt_ne_pkg.sv
sv/rrt_nearest_extend_engine.sv
test/rrt_nearest_extend_engine_tb.sv
